### rtl/core/pru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_pkg
// Shared types, constants and helpers of the pixel replicate upscaler.
// ----------------------------------------------------------------------------
package pru_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_SCALE  = 100;

  localparam int unsigned PIX_W      = 24;
  localparam int unsigned SCALE_W    = 7;
  localparam int unsigned ROW_W      = 13;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 2'd1;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_PULL = 1'b1;

  typedef enum logic [1:0] {
    ST_PIXEL  = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  typedef struct packed {
    logic       func;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } in_beat_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       row_end;
    logic [1:0] pad_bytes;
    logic       group_end;
  } out_beat_t;

  // result descriptor from the sequencer, pixel comes from the line store
  typedef struct packed {
    status_e    status;
    logic       row_end;
    logic [1:0] pad_bytes;
    logic       group_end;
  } rsp_t;

  // (width * scale) mod 4 from the low bits of both factors
  function automatic logic [1:0] pad_count(logic [1:0] w_lo, logic [1:0] s_lo);
    logic [3:0] prod;
    prod = {2'b00, w_lo} * {2'b00, s_lo};
    return prod[1:0];
  endfunction

endpackage

### rtl/core/pru_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pru_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/pru_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_ctrl
// Configuration registers, fill and replay counters, line store access.
// ----------------------------------------------------------------------------
module pru_ctrl #(
  parameter int unsigned MaxWidth = pru_pkg::MAX_WIDTH,
  parameter int unsigned MaxScale = pru_pkg::MAX_SCALE,
  localparam int unsigned AddrW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pru_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pru_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             accept_i,
  input  pru_pkg::in_beat_t                beat_i,
  output logic                             ram_we_o,
  output logic [AddrW-1:0]                 ram_waddr_o,
  output logic [pru_pkg::PIX_W-1:0]        ram_wdata_o,
  output logic                             ram_re_o,
  output logic [AddrW-1:0]                 ram_raddr_o,
  output pru_pkg::rsp_t                    rsp_o
);

  localparam int unsigned CntW = $clog2(MaxWidth + 1);
  localparam int unsigned RepW = $clog2(MaxScale + 1);

  logic [pru_pkg::SCALE_W-1:0] scale_q, scale_d;
  logic [pru_pkg::ROW_W-1:0]   row_width_q, row_width_d;
  logic [CntW-1:0]             fill_q, fill_d;
  logic [AddrW-1:0]            col_q, col_d;
  logic [RepW-1:0]             hrep_q, hrep_d;
  logic [RepW-1:0]             vrep_q, vrep_d;
  logic                        replay_q, replay_d;

  logic [CntW-1:0] w_eff;
  logic [RepW-1:0] s_eff;
  logic [CntW-1:0] fill_inc;
  logic [CntW-1:0] col_inc;
  logic [RepW-1:0] hrep_inc;
  logic [RepW-1:0] vrep_inc;
  logic            row_last;
  logic            rep_last;
  logic            vrep_last;

  // clamp registers into the supported range
  always_comb begin
    if (row_width_q == '0) begin
      w_eff = CntW'(1);
    end else if (32'(row_width_q) > 32'(MaxWidth)) begin
      w_eff = CntW'(MaxWidth);
    end else begin
      w_eff = CntW'(row_width_q);
    end
    if (scale_q == '0) begin
      s_eff = RepW'(1);
    end else if (32'(scale_q) > 32'(MaxScale)) begin
      s_eff = RepW'(MaxScale);
    end else begin
      s_eff = RepW'(scale_q);
    end
  end

  assign fill_inc  = fill_q + CntW'(1);
  assign col_inc   = CntW'(col_q) + CntW'(1);
  assign hrep_inc  = hrep_q + RepW'(1);
  assign vrep_inc  = vrep_q + RepW'(1);
  assign row_last  = (col_inc >= w_eff);
  assign rep_last  = (hrep_inc >= s_eff);
  assign vrep_last = (vrep_inc >= s_eff);

  always_comb begin
    scale_d     = scale_q;
    row_width_d = row_width_q;
    fill_d      = fill_q;
    col_d       = col_q;
    hrep_d      = hrep_q;
    vrep_d      = vrep_q;
    replay_d    = replay_q;

    ram_we_o    = 1'b0;
    ram_waddr_o = fill_q[AddrW-1:0];
    ram_wdata_o = {beat_i.in_red, beat_i.in_green, beat_i.in_blue};
    ram_re_o    = 1'b0;
    ram_raddr_o = col_q;

    rsp_o           = '0;
    rsp_o.status    = pru_pkg::ST_REJECT;

    if (cfg_we_i) begin
      if (cfg_idx_i == pru_pkg::CFG_SCALE || cfg_idx_i == pru_pkg::CFG_ROW_WIDTH) begin
        if (cfg_idx_i == pru_pkg::CFG_SCALE) begin
          scale_d = cfg_data_i[pru_pkg::SCALE_W-1:0];
        end else begin
          row_width_d = cfg_data_i[pru_pkg::ROW_W-1:0];
        end
        fill_d   = '0;
        col_d    = '0;
        hrep_d   = '0;
        vrep_d   = '0;
        replay_d = 1'b0;
      end
    end else if (accept_i) begin
      if (beat_i.func == pru_pkg::FUNC_PUSH) begin
        if (!replay_q) begin
          ram_we_o     = 1'b1;
          rsp_o.status = pru_pkg::ST_ACCEPT;
          if (fill_inc >= w_eff) begin
            fill_d   = '0;
            col_d    = '0;
            hrep_d   = '0;
            vrep_d   = '0;
            replay_d = 1'b1;
          end else begin
            fill_d = fill_inc;
          end
        end
      end else if (replay_q) begin
        ram_re_o     = 1'b1;
        rsp_o.status = pru_pkg::ST_PIXEL;
        if (row_last && rep_last) begin
          rsp_o.row_end   = 1'b1;
          rsp_o.pad_bytes = pru_pkg::pad_count(2'(w_eff), 2'(s_eff));
          rsp_o.group_end = vrep_last;
        end
        if (rep_last) begin
          hrep_d = '0;
          if (row_last) begin
            col_d = '0;
            if (vrep_last) begin
              vrep_d   = '0;
              replay_d = 1'b0;
            end else begin
              vrep_d = vrep_inc;
            end
          end else begin
            col_d = col_q + AddrW'(1);
          end
        end else begin
          hrep_d = hrep_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= pru_pkg::SCALE_W'(1);
      row_width_q <= pru_pkg::ROW_W'(1);
      fill_q      <= '0;
      col_q       <= '0;
      hrep_q      <= '0;
      vrep_q      <= '0;
      replay_q    <= 1'b0;
    end else begin
      scale_q     <= scale_d;
      row_width_q <= row_width_d;
      fill_q      <= fill_d;
      col_q       <= col_d;
      hrep_q      <= hrep_d;
      vrep_q      <= vrep_d;
      replay_q    <= replay_d;
    end
  end

  a_replay_fill_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    replay_q |-> fill_q == '0)
    else $error("fill count not cleared during replay");

  a_replay_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    replay_q |-> (hrep_q < s_eff) && (vrep_q < s_eff) && (CntW'(col_q) < w_eff))
    else $error("replay counters out of range");

  a_no_store_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |=> !replay_q || (fill_q == '0))
    else $error("line store written outside fill");

endmodule

### rtl/core/pixel_replicate_upscaler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_replicate_upscaler_top
// Nearest-neighbor integer upscaler for rows of 24-bit pixels.
// ----------------------------------------------------------------------------
// Push beats fill a line store until a row of row_width pixels is held; pull
// beats then return the row with every pixel repeated scale times, the row
// itself sent scale times, and the last pixel of each output row tagged with
// the count of zero padding bytes. Every input beat yields exactly one output
// beat, in the cycle after acceptance, through the registered line store read. An
// input beat can be taken every cycle as long as the output side takes its
// beats; while an output beat waits, the input is stalled. Configuration
// writes to the scale or row width restart the block and take effect at once.
// ----------------------------------------------------------------------------
module pixel_replicate_upscaler_top #(
  parameter int unsigned MaxWidth = pru_pkg::MAX_WIDTH,
  parameter int unsigned MaxScale = pru_pkg::MAX_SCALE
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pru_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pru_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pru_pkg::in_beat_t              in_beat_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pru_pkg::out_beat_t             out_beat_o
);

  localparam int unsigned AddrW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;

  logic                      accept;
  logic                      ram_we;
  logic [AddrW-1:0]          ram_waddr;
  logic [pru_pkg::PIX_W-1:0] ram_wdata;
  logic                      ram_re;
  logic [AddrW-1:0]          ram_raddr;
  logic [pru_pkg::PIX_W-1:0] ram_rdata;
  pru_pkg::rsp_t             rsp;
  pru_pkg::rsp_t             rsp_q;
  logic                      out_valid_q, out_valid_d;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  pru_ctrl #(
    .MaxWidth (MaxWidth),
    .MaxScale (MaxScale)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .beat_i      (in_beat_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .rsp_o       (rsp)
  );

  pru_ram #(
    .Width (pru_pkg::PIX_W),
    .Depth (MaxWidth)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp;
    end
  end

  always_comb begin
    out_beat_o           = '0;
    out_beat_o.status    = rsp_q.status;
    out_beat_o.row_end   = rsp_q.row_end;
    out_beat_o.pad_bytes = rsp_q.pad_bytes;
    out_beat_o.group_end = rsp_q.group_end;
    if (rsp_q.status == pru_pkg::ST_PIXEL) begin
      out_beat_o.out_blue  = ram_rdata[7:0];
      out_beat_o.out_green = ram_rdata[15:8];
      out_beat_o.out_red   = ram_rdata[23:16];
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted beat without result");

  a_group_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.group_end |-> out_beat_o.row_end)
    else $error("group end outside row end");

  a_pad_at_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_beat_o.row_end |-> out_beat_o.pad_bytes == 2'd0)
    else $error("padding outside row end");

endmodule

### tb/upscale_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upscale_checker
// Prediction and comparison for the pixel replicate upscaler.
// ----------------------------------------------------------------------------
// Watches the register port and both beat channels. Each accepted input beat
// is run through a model of the line store and replay counters, and the
// expected output beat is queued. Each accepted output beat is compared field
// by field with the oldest queued beat. Counts go back to the testbench top.
// ----------------------------------------------------------------------------
module upscale_checker
  import pru_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_beat_t              in_beat_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_beat_t             out_beat_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    beats_o,
  output int                    pixels_o,
  output int                    rejects_o,
  output int                    group_ends_o,
  output int                    cfg_writes_o
);

  logic [PIX_W-1:0]   line_mem [0:MAX_WIDTH-1];
  logic [SCALE_W-1:0] scale_reg;
  logic [ROW_W-1:0]   width_reg;
  int unsigned        fill_cnt;
  int unsigned        col;
  int unsigned        h_rep;
  int unsigned        v_rep;
  bit                 replay_on;

  out_beat_t expected_beats [$];
  int        errors;
  int        n_beats;
  int        n_pixels;
  int        n_rejects;
  int        n_groups;
  int        n_cfg;

  function automatic int unsigned effective_scale();
    if (scale_reg == '0) return 1;
    if (scale_reg > MAX_SCALE) return MAX_SCALE;
    return scale_reg;
  endfunction

  function automatic int unsigned effective_width();
    if (width_reg == '0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic void restart_replay();
    fill_cnt  = 0;
    col       = 0;
    h_rep     = 0;
    v_rep     = 0;
    replay_on = 1'b0;
  endfunction

  function automatic out_beat_t replicate_step(in_beat_t b);
    int unsigned w;
    int unsigned s;
    out_beat_t   r;
    w = effective_width();
    s = effective_scale();
    r = '0;
    if (b.func == FUNC_PUSH) begin
      if (replay_on) begin
        r.status = ST_REJECT;
      end else begin
        line_mem[fill_cnt] = {b.in_red, b.in_green, b.in_blue};
        fill_cnt++;
        if (fill_cnt >= w) begin
          restart_replay();
          replay_on = 1'b1;
        end
        r.status = ST_ACCEPT;
      end
    end else if (!replay_on) begin
      r.status = ST_REJECT;
    end else begin
      r.status = ST_PIXEL;
      {r.out_red, r.out_green, r.out_blue} = line_mem[col];
      r.row_end   = (col + 1 >= w) && (h_rep + 1 >= s);
      r.group_end = r.row_end && (v_rep + 1 >= s);
      if (r.row_end) r.pad_bytes = 2'((w * s) % 4);
      h_rep++;
      if (h_rep >= s) begin
        h_rep = 0;
        col++;
        if (col >= w) begin
          col = 0;
          v_rep++;
          if (v_rep >= s) begin
            v_rep     = 0;
            replay_on = 1'b0;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic log_mismatch(string what, logic [7:0] got, logic [7:0] want);
    errors++;
    $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
  endtask

  task automatic check_beat(out_beat_t got);
    out_beat_t want;
    if (expected_beats.size() == 0) begin
      log_mismatch("unexpected output beat, status", 8'(got.status), 8'h00);
      return;
    end
    want = expected_beats.pop_front();
    if (got.status !== want.status)
      log_mismatch("status", 8'(got.status), 8'(want.status));
    if (got.out_blue !== want.out_blue)
      log_mismatch("out_blue", got.out_blue, want.out_blue);
    if (got.out_green !== want.out_green)
      log_mismatch("out_green", got.out_green, want.out_green);
    if (got.out_red !== want.out_red)
      log_mismatch("out_red", got.out_red, want.out_red);
    if (got.row_end !== want.row_end)
      log_mismatch("row_end", 8'(got.row_end), 8'(want.row_end));
    if (got.pad_bytes !== want.pad_bytes)
      log_mismatch("pad_bytes", 8'(got.pad_bytes), 8'(want.pad_bytes));
    if (got.group_end !== want.group_end)
      log_mismatch("group_end", 8'(got.group_end), 8'(want.group_end));
    if (want.status == ST_PIXEL) n_pixels++;
    if (want.status == ST_REJECT) n_rejects++;
    if (want.group_end) n_groups++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_reg = SCALE_W'(1);
      width_reg = ROW_W'(1);
      restart_replay();
      expected_beats.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SCALE: begin
            scale_reg = cfg_data_i[SCALE_W-1:0];
            restart_replay();
          end
          CFG_ROW_WIDTH: begin
            width_reg = cfg_data_i[ROW_W-1:0];
            restart_replay();
          end
          default: ;
        endcase
        n_cfg++;
      end
      // result of a beat taken at this edge cannot leave before the next one
      if (out_valid_i && !out_stall_i) check_beat(out_beat_i);
      if (in_valid_i && !in_stall_i) begin
        expected_beats.push_back(replicate_step(in_beat_i));
        n_beats++;
      end
    end
    fail_count_o <= errors;
    pending_o    <= expected_beats.size();
    beats_o      <= n_beats;
    pixels_o     <= n_pixels;
    rejects_o    <= n_rejects;
    group_ends_o <= n_groups;
    cfg_writes_o <= n_cfg;
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench top for the pixel replicate upscaler.
// ----------------------------------------------------------------------------
// Drives a short directed sequence over the phase changes and register
// extremes, then random phases of fill and replay rows at random settings
// with noise beats and cut-off rows, and ends at full rate with the largest
// scale, a clamped width and a few whole rows. Both channels idle in random
// bursts; in chosen phases the output side holds off long enough to back up
// the input. The checker does the prediction; this module makes stimulus and
// gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import pru_pkg::*;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          HOLD_LEN       = 64;
  localparam int          RAND_ITEMS     = 1000;
  localparam int unsigned PULL_CAP       = 200;
  localparam int unsigned NO_LIMIT       = 32'hFFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_beat_t              in_beat  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_beat;

  int fails;
  int pending;
  int beats;
  int pixels;
  int rejects;
  int group_ends;
  int cfg_writes;

  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;
  bit          hold_req   = 1'b0;
  int unsigned cur_w      = 1;
  int unsigned cur_s      = 1;
  int          random_items;

  always #5 clk = ~clk;

  pixel_replicate_upscaler_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  upscale_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_beat_i    (in_beat),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_beat_i   (out_beat),
    .fail_count_o (fails),
    .pending_o    (pending),
    .beats_o      (beats),
    .pixels_o     (pixels),
    .rejects_o    (rejects),
    .group_ends_o (group_ends),
    .cfg_writes_o (cfg_writes)
  );

  // output side: random stall bursts, plus one long hold-off on request
  always begin
    @(posedge clk);
    if (hold_req) begin
      hold_req = 1'b0;
      out_stall <= 1'b1;
      repeat (HOLD_LEN) @(posedge clk);
      out_stall <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 11)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    wait (rst_n);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  function automatic in_beat_t pixel_beat(logic f);
    in_beat_t b;
    b.func     = f;
    b.in_blue  = 8'($urandom);
    b.in_green = 8'($urandom);
    b.in_red   = 8'($urandom);
    return b;
  endfunction

  task automatic send_beat(in_beat_t b);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic push_rgb(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    in_beat_t b;
    b.func     = FUNC_PUSH;
    b.in_blue  = blue;
    b.in_green = green;
    b.in_red   = red;
    send_beat(b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_mode(int unsigned s_raw, int unsigned w_raw);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[SCALE_W-1:0] = SCALE_W'(s_raw);
    cfg_write(CFG_SCALE, d);
    cfg_write(CFG_ROW_WIDTH, CFG_DATA_W'(w_raw));
    cur_s = (s_raw == 0) ? 1 : ((s_raw > MAX_SCALE) ? MAX_SCALE : s_raw);
    cur_w = (w_raw == 0) ? 1 : ((w_raw > MAX_WIDTH) ? MAX_WIDTH : w_raw);
  endtask

  // one source row: fill then replay; done is low when the row was cut off
  task automatic run_row(int unsigned push_limit, int unsigned pull_limit, bit noise,
                         output bit done);
    int unsigned n_pull;
    done = 1'b0;
    for (int unsigned i = 0; i < cur_w; i++) begin
      if (i >= push_limit) return;
      if (noise && $urandom_range(0, 9) == 0) send_beat(pixel_beat(FUNC_PULL));
      send_beat(pixel_beat(FUNC_PUSH));
      random_items++;
    end
    if ($urandom_range(0, 7) == 0) drain();
    n_pull = cur_w * cur_s * cur_s;
    done   = (n_pull <= pull_limit);
    if (!done) n_pull = pull_limit;
    for (int unsigned i = 0; i < n_pull; i++) begin
      if (noise && $urandom_range(0, 9) == 0) send_beat(pixel_beat(FUNC_PUSH));
      send_beat(pixel_beat(FUNC_PULL));
      random_items++;
    end
  endtask

  initial begin
    int unsigned s_pick;
    int unsigned w_pick;
    int          phase_no;
    int          rows;
    bit          done;
    bit          cut;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    // directed: idle pull, fill at reset size, push during replay, idle again
    send_beat(pixel_beat(FUNC_PULL));
    push_rgb(8'hFF, 8'hFF, 8'hFF);
    push_rgb(8'h00, 8'h00, 8'h00);
    send_beat(pixel_beat(FUNC_PULL));
    send_beat(pixel_beat(FUNC_PULL));
    cfg_write(CFG_SPARE_A, '1);
    cfg_write(CFG_SPARE_B, '1);
    push_rgb(8'h00, 8'h00, 8'h00);
    send_beat(pixel_beat(FUNC_PULL));
    set_mode(0, 0);
    push_rgb(8'hA5, 8'h5A, 8'hC3);
    send_beat(pixel_beat(FUNC_PULL));
    set_mode(2, 3);
    push_rgb(8'hFF, 8'h00, 8'hFF);
    push_rgb(8'h00, 8'hFF, 8'h00);
    push_rgb(8'h12, 8'h34, 8'h56);
    repeat (6) send_beat(pixel_beat(FUNC_PULL));
    push_rgb(8'h77, 8'h77, 8'h77);
    send_beat(pixel_beat(FUNC_PULL));
    // restart mid-replay at the largest scale field value
    set_mode(127, 2);
    push_rgb(8'h01, 8'h80, 8'hFE);
    push_rgb(8'hFE, 8'h01, 8'h80);
    repeat (3) send_beat(pixel_beat(FUNC_PULL));

    random_items = 0;
    phase_no     = 0;
    while (random_items < RAND_ITEMS) begin
      phase_no++;
      case ($urandom_range(0, 9))
        0:       begin s_pick = 0;                       w_pick = $urandom_range(1, 6); end
        1:       begin s_pick = $urandom_range(101, 127); w_pick = $urandom_range(1, 2); end
        2:       begin s_pick = $urandom_range(1, 5);     w_pick = 0;                    end
        3:       begin s_pick = $urandom_range(5, 100);   w_pick = $urandom_range(1, 3); end
        default: begin s_pick = $urandom_range(1, 4);     w_pick = $urandom_range(1, 8); end
      endcase
      set_mode(s_pick, w_pick);
      tx_idle_on = $urandom_range(0, 3) != 0;
      rx_idle_on = $urandom_range(0, 3) != 0;
      if (phase_no == 4 || phase_no == 20) begin
        tx_idle_on = 1'b0;
        hold_req   = 1'b1;
      end
      rows = $urandom_range(1, 3);
      for (int r = 0; r < rows; r++) begin
        cut = $urandom_range(0, 9) == 0;
        run_row(cut ? $urandom_range(0, cur_w - 1) : cur_w, PULL_CAP, 1'b1, done);
        if (!done) break;
      end
      repeat ($urandom_range(0, 2)) send_beat(pixel_beat(1'($urandom_range(0, 1))));
    end

    // full rate: largest scale, a clamped width and a few whole rows
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    set_mode(127, 1);
    run_row(NO_LIMIT, 150, 1'b0, done);
    send_beat(pixel_beat(FUNC_PULL));
    set_mode(MAX_SCALE, 8191);
    run_row(4, NO_LIMIT, 1'b0, done);
    set_mode(4, 7);
    run_row(NO_LIMIT, NO_LIMIT, 1'b0, done);
    set_mode(3, 5);
    run_row(NO_LIMIT, NO_LIMIT, 1'b0, done);

    drain();
    repeat (5) @(posedge clk);

    $display("covered %0d input beats, %0d output pixels, %0d rejected or idle beats",
             beats, pixels, rejects);
    $display("%0d replayed rows finished, %0d register writes, %0d random phases",
             group_ends, cfg_writes, phase_no);
    if (pending != 0) $display("%0d expected beats never arrived", pending);
    if (fails == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
